### hw/rtl/osrw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osrw_pkg
// shared types and constants of the octahedral spiral room walker
// ----------------------------------------------------------------------------
package osrw_pkg;

  localparam int COORD_BITS_DEF = 64;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_START_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_Z = 2'd2;

  typedef struct packed {
    logic vld;
    logic restart;
  } osrw_req_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

### hw/rtl/osrw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osrw_front
// request intake: two-word queue of restart flags ahead of the walker
// ----------------------------------------------------------------------------
module osrw_front
  import osrw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      in_restart,
  output osrw_req_t      req,
  input  wire logic      req_pop
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic [1:0] q_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = req_pop && (cnt_r != 2'd0);
  assign req.vld  = (cnt_r != 2'd0);
  assign req.restart = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_restart;
  end

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wp_r != rp_r)) else $error("queue pointers out of step");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |=> (cnt_r != 2'd2)) else $error("queue jumped from empty to full");
`endif

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### hw/rtl/osrw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osrw_back
// walker: shell and level counters, candidate evaluation, output register
// ----------------------------------------------------------------------------
module osrw_back
  import osrw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] start_z,
  input  wire osrw_req_t             req,
  output logic                       req_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [63:0]                out_x,
  output logic [63:0]                out_y,
  output logic [63:0]                out_z
);

  localparam int CB = COORD_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0]    state_r, state_nxt;

  logic [63:0]   wpos_r;
  logic [31:0]   shell_r, level_r, len_r, ind_r;
  logic [1:0]    side_r;

  logic [CB-1:0] cx_r, cy_r, cz_r;
  logic [CB-1:0] hx_r, y_r, z_r;
  logic          ovld_r;
  logic [CB-1:0] ox_r, oy_r, oz_r;

  // advance inputs / outputs
  logic          adv, adv_rst;
  logic [63:0]   b_wpos, n_wpos;
  logic [31:0]   b_shell, b_level, b_len, b_ind;
  logic [1:0]    b_side;
  logic [31:0]   n_shell, n_level, n_len, n_ind;
  logic [1:0]    n_side;
  logic          lvl_done;
  logic [32:0]   lvl_inc, lvl_top;

  // candidate
  logic [CB-1:0] cx_c, cy_c;
  logic          active;
  logic [31:0]   lmi;
  logic [CB-1:0] hx_c, y_c, z_c, x_c;
  logic          reach;

  // center, registered from the start registers
  always_comb begin
    cx_c = {start_x[CB-1], start_x[CB-1:1]} + CB'(start_x[0]);
    cy_c = (start_z[0] && !start_y[0]) ? start_y - CB'(1) : start_y;
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_c;
    cy_r <= cy_c;
    cz_r <= start_z;
  end

  // one walk step
  always_comb begin
    b_wpos  = adv_rst ? '1    : wpos_r;
    b_shell = adv_rst ? 32'd1 : shell_r;
    b_level = adv_rst ? 32'd1 : level_r;
    b_len   = adv_rst ? 32'd0 : len_r;
    b_ind   = adv_rst ? 32'd0 : ind_r;
    b_side  = adv_rst ? 2'd0  : side_r;

    n_wpos  = b_wpos + 64'd1;
    n_shell = b_shell;
    n_level = b_level;
    n_len   = b_len;
    n_ind   = b_ind;
    n_side  = b_side;
    lvl_done = 1'b0;
    lvl_inc = {1'b0, b_level} + 33'd1;
    lvl_top = {b_shell, 1'b1};

    if (!n_wpos[63] && (n_wpos[63:1] != 63'd0)) begin
      if (b_len == 32'd0) begin
        lvl_done = 1'b1;
      end else if (b_ind + 32'd1 == b_len) begin
        n_ind  = 32'd0;
        n_side = b_side + 2'd1;
        if (b_side == 2'd3) lvl_done = 1'b1;
      end else begin
        n_ind = b_ind + 32'd1;
      end
      if (lvl_done) begin
        n_ind  = 32'd0;
        n_side = 2'd0;
        if (lvl_inc > lvl_top) begin
          n_level = 32'd1;
          n_shell = b_shell + 32'd1;
          n_len   = 32'd0;
        end else begin
          n_level = lvl_inc[31:0];
          if (lvl_inc == lvl_top) begin
            n_len = 32'd0;
          end else if (lvl_inc <= {1'b0, b_shell} + 33'd1) begin
            n_len = b_len + 32'd1;
          end else begin
            n_len = b_len - 32'd1;
          end
        end
      end
    end
  end

  // candidate in half-x space
  always_comb begin
    active = (wpos_r != 64'd0) && !wpos_r[63];
    lmi    = len_r - ind_r;
    hx_c   = cx_r;
    y_c    = cy_r;
    z_c    = cz_r;
    if (active) begin
      z_c = cz_r + CB'(level_r) - CB'(shell_r) - CB'(1);
      if (len_r != 32'd0) begin
        case (side_r)
          2'd0: begin hx_c = cx_r - CB'(lmi);   y_c = cy_r + CB'(ind_r); end
          2'd1: begin hx_c = cx_r + CB'(ind_r); y_c = cy_r + CB'(lmi);   end
          2'd2: begin hx_c = cx_r + CB'(lmi);   y_c = cy_r - CB'(ind_r); end
          default: begin hx_c = cx_r - CB'(ind_r); y_c = cy_r - CB'(lmi); end
        endcase
      end
    end
  end

  always_comb begin
    x_c   = {hx_r[CB-2:0], 1'b0} - CB'(!y_r[0]);
    reach = (y_r[0] == z_r[0]);
  end

  always_comb begin
    state_nxt = state_r;
    adv       = 1'b0;
    adv_rst   = 1'b0;
    req_pop   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req.vld) begin
          req_pop   = 1'b1;
          adv       = 1'b1;
          adv_rst   = req.restart;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: state_nxt = S_CHECK;
      S_CHECK: begin
        if (!reach) begin
          adv       = 1'b1;
          state_nxt = S_EVAL;
        end else if (!ovld_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic load;
  assign load = (state_r == S_CHECK) && reach && (!ovld_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wpos_r  <= '1;
      shell_r <= 32'd1;
      level_r <= 32'd1;
      len_r   <= 32'd0;
      ind_r   <= 32'd0;
      side_r  <= 2'd0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        wpos_r  <= n_wpos;
        shell_r <= n_shell;
        level_r <= n_level;
        len_r   <= n_len;
        ind_r   <= n_ind;
        side_r  <= n_side;
      end
      if (load) begin
        ovld_r <= 1'b1;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      hx_r <= hx_c;
      y_r  <= y_c;
      z_r  <= z_c;
    end
    if (load) begin
      ox_r <= x_c;
      oy_r <= y_r;
      oz_r <= z_r;
    end
  end

  assign out_valid = ovld_r;
  assign out_x = 64'($signed(ox_r));
  assign out_y = 64'($signed(oy_r));
  assign out_z = 64'($signed(oz_r));

`ifndef NO_ASSERTIONS
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && req.vld && req.restart) |=> (wpos_r == 64'd0))
    else $error("restart did not return walk to center");
  a_reach: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (oy_r[0] == oz_r[0])) else $error("unreachable room delivered");
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r != 32'd0) && ({1'b0, level_r} <= {shell_r, 1'b1}))
    else $error("level out of shell");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    ((level_r == 32'd1) || ({1'b0, level_r} == {shell_r, 1'b1})) == (len_r == 32'd0))
    else $error("side length out of step with level");
`endif

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### hw/rtl/octahedral_spiral_room_walker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// octahedral_spiral_room_walker_core
// walks a 3d lattice outward from a start room in octahedral shells
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes start_x (index 0), start_y (1), start_z (2); write only
//   while no request is pending. index 3 is ignored.
//   each in word (restart flag in bit 0) asks for the next reachable room;
//   restart set returns the walk to the center first.
//   each out word carries room_x, room_y, room_z, 64 bits each.
// flow:
//   a request waits in the intake queue until the walker is idle; the walker
//   then pops it and steps its counters (S_IDLE), registers the candidate
//   coordinates (S_EVAL) and checks reachability (S_CHECK); each skipped room
//   repeats the counter step, S_EVAL and S_CHECK. at most two rooms are
//   skipped per request. the walker finishes one request before the next.
// reset:
//   clears the start registers to zero and puts the walk before its first
//   room; the queue and output register come up empty.
// stalls:
//   the result waits in the output register; the walker holds its finished
//   room and the queue takes up to two more words meanwhile.
// ----------------------------------------------------------------------------
module octahedral_spiral_room_walker_core
  import osrw_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [7:0]              in_tdata,   // restart
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [191:0]                 out_tdata,  // room_x, room_y, room_z
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [63:0]             cfg_data
);

  logic [COORD_BITS-1:0] start_x_r, start_y_r, start_z_r;
  osrw_req_t             req;
  logic                  req_pop;
  logic [63:0]           room_x, room_y, room_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      start_z_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_X: start_x_r <= cfg_data[COORD_BITS-1:0];
        CFG_START_Y: start_y_r <= cfg_data[COORD_BITS-1:0];
        CFG_START_Z: start_z_r <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  osrw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_restart (in_tdata[0]),
    .req        (req),
    .req_pop    (req_pop)
  );

  osrw_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_x   (start_x_r),
    .start_y   (start_y_r),
    .start_z   (start_z_r),
    .req       (req),
    .req_pop   (req_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (room_x),
    .out_y     (room_y),
    .out_z     (room_z)
  );

  assign out_tdata = {room_z, room_y, room_x};

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the octahedral spiral room walker core
// ----------------------------------------------------------------------------
// restart words stream in while a local model of the shell walk predicts each
// room. Start registers change between phases, extremes included. Both sides
// idle and stall at random, and the receiver is held off for a long stretch.
// Every room word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import osrw_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] z;
    logic [63:0] y;
    logic [63:0] x;
  } room_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [191:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [63:0] cfg_data;

  octahedral_spiral_room_walker_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // start registers and walk counters of the model
  logic [63:0] start_x, start_y, start_z;
  logic [63:0] walk_pos;
  logic [31:0] shell_num, level_num;
  logic [63:0] level_off;

  bit   restart_q[$];
  room_t room_q[$];
  int   send_idle_pct, recv_stall_pct;
  int   errors;
  int   hold_left, hold_req, hold_seen;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [63:0] level_rooms();
    logic [63:0] s, l;
    s = {32'b0, shell_num};
    l = {32'b0, level_num};
    if (l == 1 || l == 2 * s + 1) return 64'd1;
    if (l <= s + 1) return 4 * (l - 1);
    return 4 * (2 * s + 1 - l);
  endfunction

  function automatic void walk_step();
    walk_pos = walk_pos + 1;
    if (walk_pos[63] || walk_pos < 2) return;
    level_off = level_off + 1;
    if (level_off >= level_rooms()) begin
      level_off = 0;
      level_num = level_num + 1;
      if ({32'b0, level_num} > 2 * {32'b0, shell_num} + 1) begin
        level_num = 1;
        shell_num = shell_num + 1;
      end
    end
  endfunction

  function automatic room_t current_room();
    logic [63:0] cx, cy, cz, hx, y, z, len, side, ind;
    room_t r;
    cx = {start_x[63], start_x[63:1]} + {63'b0, start_x[0]};
    cy = start_y;
    cz = start_z;
    if (cz[0] && !cy[0]) cy = cy - 1;
    hx = cx;
    y = cy;
    z = cz;
    if (walk_pos != 0 && !walk_pos[63]) begin
      len = level_rooms() >> 2;
      z = cz + {32'b0, level_num} - {32'b0, shell_num} - 1;
      if (len != 0) begin
        side = level_off / len;
        ind = level_off % len;
        case (side)
          0: begin hx = cx - (len - ind); y = cy + ind; end
          1: begin hx = cx + ind; y = cy + (len - ind); end
          2: begin hx = cx + (len - ind); y = cy - ind; end
          3: begin hx = cx - ind; y = cy - (len - ind); end
          default: ;
        endcase
      end
    end
    r.x = 2 * hx - (y[0] ? 64'd0 : 64'd1);
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic room_t next_room(bit restart);
    room_t r;
    if (restart) begin
      walk_pos = '1;
      shell_num = 1;
      level_num = 1;
      level_off = 0;
    end
    do begin
      walk_step();
      r = current_room();
    end while (r.z[0] ? r.x[0] : r.y[0]);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) room_q.push_back(next_room(in_tdata[0]));
      if (!in_tvalid || in_tready) begin
        if (restart_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {7'b0, restart_q.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_left <= 300;
      hold_seen <= hold_req;
    end
  end

  // monitor
  always @(posedge clk) begin
    room_t exp_room, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (room_q.size() == 0) begin
          $display("%0t unexpected word x=%h y=%h z=%h", $time, got.x, got.y, got.z);
          errors++;
        end else begin
          exp_room = room_q.pop_front();
          if (got.x !== exp_room.x) begin
            $display("%0t room_x exp %h got %h", $time, exp_room.x, got.x);
            errors++;
          end
          if (got.y !== exp_room.y) begin
            $display("%0t room_y exp %h got %h", $time, exp_room.y, got.y);
            errors++;
          end
          if (got.z !== exp_room.z) begin
            $display("%0t room_z exp %h got %h", $time, exp_room.z, got.z);
            errors++;
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_X: start_x = val;
      CFG_START_Y: start_y = val;
      CFG_START_Z: start_z = val;
      default: ;
    endcase
  endtask

  task automatic set_start(logic [63:0] x, logic [63:0] y, logic [63:0] z);
    write_reg(CFG_START_X, x);
    write_reg(CFG_START_Y, y);
    write_reg(CFG_START_Z, z);
  endtask

  task automatic drain();
    @(negedge clk);
    while (restart_q.size() != 0 || in_tvalid || room_q.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_run(int n, int restart_pct);
    @(negedge clk);
    repeat (n) restart_q.push_back($urandom_range(99) < restart_pct);
  endtask

  initial begin
    errors = 0;
    hold_req = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    start_x = '0; start_y = '0; start_z = '0;
    walk_pos = '1; shell_num = 1; level_num = 1; level_off = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_X;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: walk from origin through the first shells, then restarts
    @(negedge clk);
    repeat (14) restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    drain();

    // extremes of the start room, odd floor with even y
    set_start(S64_MAX, S64_MIN, 64'd1);
    write_reg(CFG_UNUSED, '1);
    @(negedge clk);
    restart_q.push_back(1'b1);
    repeat (4) restart_q.push_back(1'b0);
    drain();
    set_start(S64_MIN, S64_MAX, S64_MAX);
    @(negedge clk);
    repeat (4) restart_q.push_back(1'b0);
    drain();

    send_idle_pct = 46;
    set_start(-64'sd7, 64'd10, -64'sd3);
    random_run(170, 2);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 46;
    set_start($urandom(), {$urandom(), $urandom()}, {$urandom(), $urandom()});
    random_run(170, 2);
    @(negedge clk);
    hold_req = hold_req + 1;
    drain();

    send_idle_pct = 36;
    recv_stall_pct = 36;
    set_start({$urandom(), $urandom()}, 64'd4, 64'd0);
    random_run(170, 3);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_start(64'd0, 64'd0, 64'd0);
    random_run(170, 0);
    drain();

    send_idle_pct = 20;
    recv_stall_pct = 20;
    set_start(S64_MAX, S64_MAX, S64_MIN);
    random_run(140, 5);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
